// ===== rtl/cpd_pkg.sv =====
// Shared types, constants and the per-camera microprogram for the camera projection block.
// No dependencies; used by camera_projection_with_distortion_top.
package cpd_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int MAX_CAMERAS   = 64;
   localparam int WORDS_PER_CAM = 23;
   localparam int TABLE_DEPTH   = MAX_CAMERAS * WORDS_PER_CAM;
   localparam int ADDR_W        = $clog2(TABLE_DEPTH);
   localparam int CAM_W         = $clog2(MAX_CAMERAS);
   localparam int COUNT_W       = 7;
   localparam int OPND_W        = 33;
   localparam int PROD_W        = 2 * OPND_W;
   localparam int ACC_W         = PROD_W + 1;
   localparam int QUO_W         = 32 + FRAC_BITS + 1;
   localparam int REM_W         = 36;
   localparam int PC_W          = 6;

   localparam logic [PC_W-1:0] PC_CAM = PC_W'(2);

   localparam logic [0:0] OP_WRITE   = 1'b0;
   localparam logic [0:0] OP_PROJECT = 1'b1;

   localparam logic [1:0] CSR_CAMERA_COUNT = 2'd0;
   localparam logic [1:0] CSR_CHUNK_SCALE  = 2'd1;
   localparam logic [1:0] CSR_IMAGE_SCALE  = 2'd2;

   localparam logic [4:0] W_K1 = 5'd12, W_K2 = 5'd13, W_K3 = 5'd14, W_K4 = 5'd15;
   localparam logic [4:0] W_P1 = 5'd16, W_P2 = 5'd17, W_F = 5'd18;
   localparam logic [4:0] W_WIDTH = 5'd19, W_HEIGHT = 5'd20, W_CX = 5'd21, W_CY = 5'd22;
   localparam logic [4:0] W_LAST = 5'd22;

   typedef struct packed {
      logic [0:0]  operation;
      logic [5:0]  camera_slot;
      logic [4:0]  word_index;
      logic [31:0] word_value;
      logic [31:0] point_x;
      logic [31:0] point_y;
      logic [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic [5:0]  camera_number;
      logic [31:0] pixel_u;
      logic [31:0] pixel_v;
      logic [30:0] distance;
      logic        in_view;
      logic        depth_invalid;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      UOP_MUL, UOP_MULX, UOP_ADD, UOP_SUB, UOP_HALF, UOP_ONE,
      UOP_DIV, UOP_SQRT, UOP_ZCHK, UOP_EMIT
   } uop_kind_type;

   typedef enum logic [4:0] {
      SRC_WORD, SRC_PTX, SRC_PTY, SRC_PTZ, SRC_CAM0, SRC_CAM1, SRC_CAM2,
      SRC_XN, SRC_YN, SRC_R2, SRC_R4, SRC_R6, SRC_R8, SRC_RAD, SRC_CROSS,
      SRC_TMP, SRC_PX, SRC_PY, SRC_DX, SRC_DY, SRC_DZ, SRC_NORM, SRC_PU,
      SRC_PV, SRC_ISC, SRC_CSC
   } src_type;

   typedef enum logic [4:0] {
      DST_NONE, DST_LIMU, DST_LIMV, DST_CAM0, DST_CAM1, DST_CAM2, DST_XN,
      DST_YN, DST_R2, DST_R4, DST_R6, DST_R8, DST_RAD, DST_CROSS, DST_TMP,
      DST_PX, DST_PY, DST_DX, DST_DY, DST_DZ, DST_NORM, DST_DIST, DST_PU, DST_PV
   } dst_type;

   typedef struct packed {
      uop_kind_type kind;
      logic         clr;
      logic         dbl;
      logic [4:0]   word;
      src_type      asel;
      src_type      bsel;
      dst_type      dst;
   } uop_type;

   function automatic uop_type mk(uop_kind_type k, logic c, logic d, logic [4:0] w,
                                  src_type a, src_type b, dst_type t);
      uop_type u;
      u.kind = k; u.clr = c; u.dbl = d; u.word = w;
      u.asel = a; u.bsel = b; u.dst = t;
      return u;
   endfunction

   // Program 0-1 runs once per projection (camera 0 limits); 2 onward runs per camera.
   function automatic uop_type uop_rom(logic [PC_W-1:0] pc);
      uop_type u;
      unique case (pc)
         6'd0:  u = mk(UOP_MUL, 1, 0, W_WIDTH, SRC_WORD, SRC_ISC, DST_LIMU);
         6'd1:  u = mk(UOP_MUL, 1, 0, W_HEIGHT, SRC_WORD, SRC_ISC, DST_LIMV);
         6'd2:  u = mk(UOP_MUL, 1, 0, 5'd0, SRC_WORD, SRC_PTX, DST_NONE);
         6'd3:  u = mk(UOP_MUL, 0, 0, 5'd1, SRC_WORD, SRC_PTY, DST_NONE);
         6'd4:  u = mk(UOP_MUL, 0, 0, 5'd2, SRC_WORD, SRC_PTZ, DST_NONE);
         6'd5:  u = mk(UOP_ADD, 0, 0, 5'd3, SRC_WORD, SRC_WORD, DST_CAM0);
         6'd6:  u = mk(UOP_MUL, 1, 0, 5'd4, SRC_WORD, SRC_PTX, DST_NONE);
         6'd7:  u = mk(UOP_MUL, 0, 0, 5'd5, SRC_WORD, SRC_PTY, DST_NONE);
         6'd8:  u = mk(UOP_MUL, 0, 0, 5'd6, SRC_WORD, SRC_PTZ, DST_NONE);
         6'd9:  u = mk(UOP_ADD, 0, 0, 5'd7, SRC_WORD, SRC_WORD, DST_CAM1);
         6'd10: u = mk(UOP_MUL, 1, 0, 5'd8, SRC_WORD, SRC_PTX, DST_NONE);
         6'd11: u = mk(UOP_MUL, 0, 0, 5'd9, SRC_WORD, SRC_PTY, DST_NONE);
         6'd12: u = mk(UOP_MUL, 0, 0, 5'd10, SRC_WORD, SRC_PTZ, DST_NONE);
         6'd13: u = mk(UOP_ADD, 0, 0, 5'd11, SRC_WORD, SRC_WORD, DST_CAM2);
         6'd14: u = mk(UOP_ZCHK, 0, 0, 5'd0, SRC_CAM2, SRC_CAM2, DST_NONE);
         6'd15: u = mk(UOP_DIV, 1, 0, 5'd0, SRC_CAM0, SRC_CAM2, DST_XN);
         6'd16: u = mk(UOP_DIV, 1, 0, 5'd0, SRC_CAM1, SRC_CAM2, DST_YN);
         6'd17: u = mk(UOP_MUL, 1, 0, 5'd0, SRC_XN, SRC_XN, DST_NONE);
         6'd18: u = mk(UOP_MUL, 0, 0, 5'd0, SRC_YN, SRC_YN, DST_R2);
         6'd19: u = mk(UOP_MUL, 1, 0, 5'd0, SRC_R2, SRC_R2, DST_R4);
         6'd20: u = mk(UOP_MUL, 1, 0, 5'd0, SRC_R4, SRC_R2, DST_R6);
         6'd21: u = mk(UOP_MUL, 1, 0, 5'd0, SRC_R4, SRC_R4, DST_R8);
         6'd22: u = mk(UOP_ONE, 1, 0, 5'd0, SRC_R2, SRC_R2, DST_NONE);
         6'd23: u = mk(UOP_MUL, 0, 0, W_K1, SRC_WORD, SRC_R2, DST_NONE);
         6'd24: u = mk(UOP_MUL, 0, 0, W_K2, SRC_WORD, SRC_R4, DST_NONE);
         6'd25: u = mk(UOP_MUL, 0, 0, W_K3, SRC_WORD, SRC_R6, DST_NONE);
         6'd26: u = mk(UOP_MUL, 0, 0, W_K4, SRC_WORD, SRC_R8, DST_RAD);
         6'd27: u = mk(UOP_MUL, 1, 0, 5'd0, SRC_XN, SRC_YN, DST_CROSS);
         6'd28: u = mk(UOP_ADD, 1, 0, 5'd0, SRC_R2, SRC_R2, DST_NONE);
         6'd29: u = mk(UOP_MUL, 0, 1, 5'd0, SRC_XN, SRC_XN, DST_TMP);
         6'd30: u = mk(UOP_MUL, 1, 0, 5'd0, SRC_XN, SRC_RAD, DST_NONE);
         6'd31: u = mk(UOP_MUL, 0, 0, W_P1, SRC_WORD, SRC_TMP, DST_NONE);
         6'd32: u = mk(UOP_MUL, 0, 1, W_P2, SRC_WORD, SRC_CROSS, DST_PX);
         6'd33: u = mk(UOP_ADD, 1, 0, 5'd0, SRC_R2, SRC_R2, DST_NONE);
         6'd34: u = mk(UOP_MUL, 0, 1, 5'd0, SRC_YN, SRC_YN, DST_TMP);
         6'd35: u = mk(UOP_MUL, 1, 0, 5'd0, SRC_YN, SRC_RAD, DST_NONE);
         6'd36: u = mk(UOP_MUL, 0, 0, W_P1, SRC_WORD, SRC_TMP, DST_NONE);
         6'd37: u = mk(UOP_MUL, 0, 1, W_P2, SRC_WORD, SRC_CROSS, DST_PY);
         6'd38: u = mk(UOP_ADD, 1, 0, 5'd0, SRC_PX, SRC_PX, DST_NONE);
         6'd39: u = mk(UOP_SUB, 0, 0, 5'd0, SRC_CAM0, SRC_CAM0, DST_DX);
         6'd40: u = mk(UOP_ADD, 1, 0, 5'd0, SRC_PY, SRC_PY, DST_NONE);
         6'd41: u = mk(UOP_SUB, 0, 0, 5'd0, SRC_CAM1, SRC_CAM1, DST_DY);
         6'd42: u = mk(UOP_SUB, 1, 0, 5'd0, SRC_CAM2, SRC_CAM2, DST_DZ);
         6'd43: u = mk(UOP_MULX, 1, 0, 5'd0, SRC_DX, SRC_DX, DST_NONE);
         6'd44: u = mk(UOP_MULX, 0, 0, 5'd0, SRC_DY, SRC_DY, DST_NONE);
         6'd45: u = mk(UOP_MULX, 0, 0, 5'd0, SRC_DZ, SRC_DZ, DST_NONE);
         6'd46: u = mk(UOP_SQRT, 1, 0, 5'd0, SRC_DZ, SRC_DZ, DST_NORM);
         6'd47: u = mk(UOP_MUL, 1, 0, 5'd0, SRC_NORM, SRC_CSC, DST_DIST);
         6'd48: u = mk(UOP_HALF, 1, 0, W_WIDTH, SRC_WORD, SRC_WORD, DST_NONE);
         6'd49: u = mk(UOP_ADD, 0, 0, W_CX, SRC_WORD, SRC_WORD, DST_NONE);
         6'd50: u = mk(UOP_MUL, 0, 0, W_F, SRC_PX, SRC_WORD, DST_PU);
         6'd51: u = mk(UOP_MUL, 1, 0, 5'd0, SRC_PU, SRC_ISC, DST_PU);
         6'd52: u = mk(UOP_HALF, 1, 0, W_HEIGHT, SRC_WORD, SRC_WORD, DST_NONE);
         6'd53: u = mk(UOP_ADD, 0, 0, W_CY, SRC_WORD, SRC_WORD, DST_NONE);
         6'd54: u = mk(UOP_MUL, 0, 0, W_F, SRC_PY, SRC_WORD, DST_PV);
         6'd55: u = mk(UOP_MUL, 1, 0, 5'd0, SRC_PV, SRC_ISC, DST_PV);
         default: u = mk(UOP_EMIT, 0, 0, 5'd0, SRC_PX, SRC_PX, DST_NONE);
      endcase
      return u;
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (v > ACC_W'(64'sh7FFFFFFF))       r = 32'sh7FFFFFFF;
      else if (v < -(ACC_W'(64'sh80000000))) r = 32'sh80000000;
      else                                  r = v[31:0];
      return r;
   endfunction

endpackage

// ===== rtl/camera_projection_with_distortion_top.sv =====
// Top level of the camera projection block: camera table memory, sequencer and shared datapath.
// Depends on cpd_pkg.
//
// Pinhole projection with radial/tangential lens distortion over a table of up to 64 cameras.
// A write beat (operation 0) stores one signed Q16.16 table word and returns no result. A
// project beat (operation 1) walks cameras 0 .. camera_count-1 and returns one result beat per
// camera, with last set on the final one; req_ready stays low until that last beat has been
// handed to the output register. Every step runs on one shared datapath: a 33x33 multiplier
// with a rounding accumulator, and a one-bit-per-cycle shift-subtract unit used for both the
// divide and the square root. A multiply, add or load step passes through the fetch, operand,
// multiply and accumulate states; a divide or square root iterates the shift-subtract unit in
// place of the multiply state. A camera with zero depth goes straight to its result, and a
// projection can stall on rsp_ready. The table has no reset; reading a word that was never
// written gives an undefined result. Configuration must be written through
// csr_we/csr_index/csr_wdata only while the block is idle; the block itself does not enforce this.
module camera_projection_with_distortion_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cpd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cpd_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [30:0]      csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_OPER, ST_MUL, ST_ITER, ST_ACC, ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [cpd_pkg::PC_W-1:0]    pc_ff, pc_in;
   logic [cpd_pkg::CAM_W-1:0]   cam_ff, cam_in;
   logic [cpd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [30:0] csc_ff, csc_in, isc_ff, isc_in;
   logic signed [31:0] ptx_ff, ptx_in, pty_ff, pty_in, ptz_ff, ptz_in;
   logic signed [31:0] cam0_ff, cam0_in, cam1_ff, cam1_in, cam2_ff, cam2_in;
   logic signed [31:0] xn_ff, xn_in, yn_ff, yn_in, r2_ff, r2_in, r4_ff, r4_in;
   logic signed [31:0] r6_ff, r6_in, r8_ff, r8_in, rad_ff, rad_in, cross_ff, cross_in;
   logic signed [31:0] tmp_ff, tmp_in, px_ff, px_in, py_ff, py_in;
   logic signed [31:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic signed [31:0] pu_ff, pu_in, pv_ff, pv_in, limu_ff, limu_in, limv_ff, limv_in;
   logic [31:0] norm_ff, norm_in;
   logic [30:0] dist_ff, dist_in;
   logic signed [cpd_pkg::OPND_W-1:0] a_ff, a_in, b_ff, b_in;
   logic signed [cpd_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [cpd_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [63:0] sh_ff, sh_in;
   logic [cpd_pkg::REM_W-1:0] rem_ff, rem_in;
   logic [cpd_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  it_ff, it_in;
   logic        zinv_ff, zinv_in;
   logic        rsp_valid_ff, rsp_valid_in;
   cpd_pkg::rsp_type rsp_ff, rsp_in;

   logic [31:0] mem [cpd_pkg::TABLE_DEPTH];
   logic [31:0] rd_ff;
   logic [cpd_pkg::ADDR_W-1:0] rd_addr, wr_addr;
   logic        wr_en;

   cpd_pkg::uop_type uop;
   logic signed [cpd_pkg::OPND_W-1:0] a_src, b_src;
   logic [cpd_pkg::COUNT_W-1:0] count_eff;
   logic        is_last;
   logic        req_fire;
   logic signed [cpd_pkg::ACC_W-1:0] rnd, term, acc_new;
   logic signed [31:0] acc_sat;
   logic [cpd_pkg::REM_W-1:0] rem_div, rem_sqrt, trial;
   logic [31:0] abs_a, abs_b;

   assign uop       = cpd_pkg::uop_rom(pc_ff);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Camera count: zero acts as one, above the table size clamps to it.
   always_comb begin
      if (count_ff == '0) count_eff = cpd_pkg::COUNT_W'(1);
      else if (count_ff > cpd_pkg::COUNT_W'(cpd_pkg::MAX_CAMERAS))
         count_eff = cpd_pkg::COUNT_W'(cpd_pkg::MAX_CAMERAS);
      else count_eff = count_ff;
   end
   assign is_last = ((cpd_pkg::COUNT_W'(cam_ff) + cpd_pkg::COUNT_W'(1)) == count_eff);

   // Table addressing: one write port from the request side, one registered read port.
   assign rd_addr = cpd_pkg::ADDR_W'(cam_ff * cpd_pkg::WORDS_PER_CAM) +
                    cpd_pkg::ADDR_W'(uop.word);
   assign wr_addr = cpd_pkg::ADDR_W'(req_data.camera_slot * cpd_pkg::WORDS_PER_CAM) +
                    cpd_pkg::ADDR_W'(req_data.word_index);
   assign wr_en   = req_fire && (req_data.operation == cpd_pkg::OP_WRITE) &&
                    (7'(req_data.camera_slot) < 7'(cpd_pkg::MAX_CAMERAS)) &&
                    (req_data.word_index <= cpd_pkg::W_LAST);

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= req_data.word_value;
      rd_ff <= mem[rd_addr];
   end

   // Operand select for the shared unit.
   function automatic logic signed [cpd_pkg::OPND_W-1:0] pick(cpd_pkg::src_type s,
      logic [31:0] w, logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] pz,
      logic signed [31:0] c0, logic signed [31:0] c1, logic signed [31:0] c2,
      logic signed [31:0] xn, logic signed [31:0] yn, logic signed [31:0] r2,
      logic signed [31:0] r4, logic signed [31:0] r6, logic signed [31:0] r8,
      logic signed [31:0] rad, logic signed [31:0] cr, logic signed [31:0] tm,
      logic signed [31:0] qx, logic signed [31:0] qy, logic signed [31:0] dx,
      logic signed [31:0] dy, logic signed [31:0] dz, logic [31:0] nrm,
      logic signed [31:0] pu, logic signed [31:0] pv, logic [30:0] isc, logic [30:0] csc);
      logic signed [cpd_pkg::OPND_W-1:0] r;
      case (s)
         cpd_pkg::SRC_WORD:  r = {w[31], w};
         cpd_pkg::SRC_PTX:   r = {px[31], px};
         cpd_pkg::SRC_PTY:   r = {py[31], py};
         cpd_pkg::SRC_PTZ:   r = {pz[31], pz};
         cpd_pkg::SRC_CAM0:  r = {c0[31], c0};
         cpd_pkg::SRC_CAM1:  r = {c1[31], c1};
         cpd_pkg::SRC_CAM2:  r = {c2[31], c2};
         cpd_pkg::SRC_XN:    r = {xn[31], xn};
         cpd_pkg::SRC_YN:    r = {yn[31], yn};
         cpd_pkg::SRC_R2:    r = {r2[31], r2};
         cpd_pkg::SRC_R4:    r = {r4[31], r4};
         cpd_pkg::SRC_R6:    r = {r6[31], r6};
         cpd_pkg::SRC_R8:    r = {r8[31], r8};
         cpd_pkg::SRC_RAD:   r = {rad[31], rad};
         cpd_pkg::SRC_CROSS: r = {cr[31], cr};
         cpd_pkg::SRC_TMP:   r = {tm[31], tm};
         cpd_pkg::SRC_PX:    r = {qx[31], qx};
         cpd_pkg::SRC_PY:    r = {qy[31], qy};
         cpd_pkg::SRC_DX:    r = {dx[31], dx};
         cpd_pkg::SRC_DY:    r = {dy[31], dy};
         cpd_pkg::SRC_DZ:    r = {dz[31], dz};
         cpd_pkg::SRC_NORM:  r = {1'b0, nrm};
         cpd_pkg::SRC_PU:    r = {pu[31], pu};
         cpd_pkg::SRC_PV:    r = {pv[31], pv};
         cpd_pkg::SRC_ISC:   r = {2'b00, isc};
         cpd_pkg::SRC_CSC:   r = {2'b00, csc};
         default:            r = '0;
      endcase
      return r;
   endfunction

   assign a_src = pick(uop.asel, rd_ff, ptx_ff, pty_ff, ptz_ff, cam0_ff, cam1_ff, cam2_ff,
                       xn_ff, yn_ff, r2_ff, r4_ff, r6_ff, r8_ff, rad_ff, cross_ff, tmp_ff,
                       px_ff, py_ff, dx_ff, dy_ff, dz_ff, norm_ff, pu_ff, pv_ff,
                       isc_ff, csc_ff);
   assign b_src = pick(uop.bsel, rd_ff, ptx_ff, pty_ff, ptz_ff, cam0_ff, cam1_ff, cam2_ff,
                       xn_ff, yn_ff, r2_ff, r4_ff, r6_ff, r8_ff, rad_ff, cross_ff, tmp_ff,
                       px_ff, py_ff, dx_ff, dy_ff, dz_ff, norm_ff, pu_ff, pv_ff,
                       isc_ff, csc_ff);

   assign abs_a = a_src[32] ? 32'(-a_src) : a_src[31:0];
   assign abs_b = b_src[32] ? 32'(-b_src) : b_src[31:0];

   // Shift-subtract step: one quotient bit or one root bit per cycle.
   assign rem_div  = {rem_ff[cpd_pkg::REM_W-2:0], sh_ff[63]};
   assign rem_sqrt = {rem_ff[cpd_pkg::REM_W-3:0], sh_ff[63:62]};
   assign trial    = {quo_ff[cpd_pkg::REM_W-3:0], 2'b01};

   // Accumulator term for the current step.
   always_comb begin
      rnd = (cpd_pkg::ACC_W'(prod_ff) + cpd_pkg::ACC_W'(1 << (cpd_pkg::FRAC_BITS - 1)))
            >>> cpd_pkg::FRAC_BITS;
      case (uop.kind)
         cpd_pkg::UOP_MUL:  term = uop.dbl ? (rnd <<< 1) : rnd;
         cpd_pkg::UOP_MULX: term = cpd_pkg::ACC_W'(prod_ff);
         cpd_pkg::UOP_ADD:  term = cpd_pkg::ACC_W'(a_ff);
         cpd_pkg::UOP_SUB:  term = -cpd_pkg::ACC_W'(a_ff);
         cpd_pkg::UOP_HALF: term = cpd_pkg::ACC_W'(a_ff) >>> 1;
         cpd_pkg::UOP_ONE:  term = cpd_pkg::ACC_W'(1 << cpd_pkg::FRAC_BITS);
         cpd_pkg::UOP_DIV: begin
            // Saturate the magnitude quotient to the signed 32-bit range.
            if (neg_ff)
               term = (quo_ff >= cpd_pkg::QUO_W'(64'h80000000)) ?
                      -cpd_pkg::ACC_W'(64'h80000000) : -cpd_pkg::ACC_W'({1'b0, quo_ff});
            else
               term = (quo_ff >= cpd_pkg::QUO_W'(64'h7FFFFFFF)) ?
                      cpd_pkg::ACC_W'(64'h7FFFFFFF) : cpd_pkg::ACC_W'({1'b0, quo_ff});
         end
         cpd_pkg::UOP_SQRT: term = cpd_pkg::ACC_W'({1'b0, quo_ff[31:0]});
         default:           term = '0;
      endcase
      acc_new = (uop.clr ? '0 : acc_ff) + term;
      acc_sat = cpd_pkg::sat32(acc_new);
   end

   always_comb begin
      state_in = state_ff;   pc_in = pc_ff;       cam_in = cam_ff;
      count_in = count_ff;   csc_in = csc_ff;     isc_in = isc_ff;
      ptx_in = ptx_ff;       pty_in = pty_ff;     ptz_in = ptz_ff;
      cam0_in = cam0_ff;     cam1_in = cam1_ff;   cam2_in = cam2_ff;
      xn_in = xn_ff;         yn_in = yn_ff;       r2_in = r2_ff;     r4_in = r4_ff;
      r6_in = r6_ff;         r8_in = r8_ff;       rad_in = rad_ff;   cross_in = cross_ff;
      tmp_in = tmp_ff;       px_in = px_ff;       py_in = py_ff;
      dx_in = dx_ff;         dy_in = dy_ff;       dz_in = dz_ff;
      pu_in = pu_ff;         pv_in = pv_ff;       limu_in = limu_ff; limv_in = limv_ff;
      norm_in = norm_ff;     dist_in = dist_ff;
      a_in = a_ff;           b_in = b_ff;         prod_in = prod_ff; acc_in = acc_ff;
      sh_in = sh_ff;         rem_in = rem_ff;     quo_in = quo_ff;   den_in = den_ff;
      neg_in = neg_ff;       it_in = it_ff;       zinv_in = zinv_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // Configuration writes must arrive only while idle; the block does not enforce this.
      if (csr_we) begin
         unique case (csr_index)
            cpd_pkg::CSR_CAMERA_COUNT: count_in = csr_wdata[cpd_pkg::COUNT_W-1:0];
            cpd_pkg::CSR_CHUNK_SCALE:  csc_in = csr_wdata;
            cpd_pkg::CSR_IMAGE_SCALE:  isc_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.operation == cpd_pkg::OP_PROJECT)) begin
               ptx_in = req_data.point_x;
               pty_in = req_data.point_y;
               ptz_in = req_data.point_z;
               cam_in = '0;
               pc_in = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            // Table read is in flight; control steps resolve here.
            if (uop.kind == cpd_pkg::UOP_ZCHK) begin
               if (cam2_ff == '0) begin
                  zinv_in = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  pc_in = pc_ff + cpd_pkg::PC_W'(1);
               end
            end else if (uop.kind == cpd_pkg::UOP_EMIT) begin
               zinv_in = 1'b0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_OPER;
            end
         end
         ST_OPER: begin
            a_in = a_src;
            b_in = b_src;
            rem_in = '0;
            quo_in = '0;
            if (uop.kind == cpd_pkg::UOP_DIV) begin
               sh_in = {abs_a, cpd_pkg::FRAC_BITS'(0), (64 - 32 - cpd_pkg::FRAC_BITS)'(0)};
               den_in = abs_b;
               neg_in = a_src[32] ^ b_src[32];
               it_in = 6'(32 + cpd_pkg::FRAC_BITS - 1);
               state_in = ST_ITER;
            end else if (uop.kind == cpd_pkg::UOP_SQRT) begin
               sh_in = acc_ff[63:0];
               it_in = 6'd31;
               state_in = ST_ITER;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = a_ff * b_ff;
            state_in = ST_ACC;
         end
         ST_ITER: begin
            if (uop.kind == cpd_pkg::UOP_DIV) begin
               sh_in = {sh_ff[62:0], 1'b0};
               if (rem_div >= cpd_pkg::REM_W'(den_ff)) begin
                  rem_in = rem_div - cpd_pkg::REM_W'(den_ff);
                  quo_in = {quo_ff[cpd_pkg::QUO_W-2:0], 1'b1};
               end else begin
                  rem_in = rem_div;
                  quo_in = {quo_ff[cpd_pkg::QUO_W-2:0], 1'b0};
               end
            end else begin
               sh_in = {sh_ff[61:0], 2'b00};
               if (rem_sqrt >= trial) begin
                  rem_in = rem_sqrt - trial;
                  quo_in = {quo_ff[cpd_pkg::QUO_W-2:0], 1'b1};
               end else begin
                  rem_in = rem_sqrt;
                  quo_in = {quo_ff[cpd_pkg::QUO_W-2:0], 1'b0};
               end
            end
            if (it_ff == '0) state_in = ST_ACC;
            else it_in = it_ff - 6'd1;
         end
         ST_ACC: begin
            acc_in = acc_new;
            case (uop.dst)
               cpd_pkg::DST_LIMU:  limu_in = acc_sat;
               cpd_pkg::DST_LIMV:  limv_in = acc_sat;
               cpd_pkg::DST_CAM0:  cam0_in = acc_sat;
               cpd_pkg::DST_CAM1:  cam1_in = acc_sat;
               cpd_pkg::DST_CAM2:  cam2_in = acc_sat;
               cpd_pkg::DST_XN:    xn_in = acc_sat;
               cpd_pkg::DST_YN:    yn_in = acc_sat;
               cpd_pkg::DST_R2:    r2_in = acc_sat;
               cpd_pkg::DST_R4:    r4_in = acc_sat;
               cpd_pkg::DST_R6:    r6_in = acc_sat;
               cpd_pkg::DST_R8:    r8_in = acc_sat;
               cpd_pkg::DST_RAD:   rad_in = acc_sat;
               cpd_pkg::DST_CROSS: cross_in = acc_sat;
               cpd_pkg::DST_TMP:   tmp_in = acc_sat;
               cpd_pkg::DST_PX:    px_in = acc_sat;
               cpd_pkg::DST_PY:    py_in = acc_sat;
               cpd_pkg::DST_DX:    dx_in = acc_sat;
               cpd_pkg::DST_DY:    dy_in = acc_sat;
               cpd_pkg::DST_DZ:    dz_in = acc_sat;
               cpd_pkg::DST_NORM:  norm_in = acc_new[31:0];
               cpd_pkg::DST_DIST:  dist_in = acc_sat[30:0];
               cpd_pkg::DST_PU:    pu_in = acc_sat;
               cpd_pkg::DST_PV:    pv_in = acc_sat;
               default: ;
            endcase
            pc_in = pc_ff + cpd_pkg::PC_W'(1);
            state_in = ST_FETCH;
         end
         ST_EMIT: begin
            // Load the output register once free; then the next camera, or idle after the last.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.camera_number = 6'(cam_ff);
               rsp_in.last = is_last;
               rsp_in.depth_invalid = zinv_ff;
               if (zinv_ff) begin
                  rsp_in.pixel_u = '0;
                  rsp_in.pixel_v = '0;
                  rsp_in.distance = '0;
                  rsp_in.in_view = 1'b0;
               end else begin
                  rsp_in.pixel_u = pu_ff;
                  rsp_in.pixel_v = pv_ff;
                  rsp_in.distance = dist_ff;
                  rsp_in.in_view = (pu_ff > 0) && (pu_ff < limu_ff) &&
                                   (pv_ff > 0) && (pv_ff < limv_ff);
               end
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cam_in = cam_ff + cpd_pkg::CAM_W'(1);
                  pc_in = cpd_pkg::PC_CAM;
                  state_in = ST_FETCH;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff <= '0;
         cam_ff <= '0;
         count_ff <= cpd_pkg::COUNT_W'(1);
         csc_ff <= 31'(1 << cpd_pkg::FRAC_BITS);
         isc_ff <= 31'(1 << (cpd_pkg::FRAC_BITS - 1));
         rsp_valid_ff <= 1'b0;
         zinv_ff <= 1'b0;
         it_ff <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         cam_ff <= cam_in;
         count_ff <= count_in;
         csc_ff <= csc_in;
         isc_ff <= isc_in;
         rsp_valid_ff <= rsp_valid_in;
         zinv_ff <= zinv_in;
         it_ff <= it_in;
      end
      ptx_ff <= ptx_in;     pty_ff <= pty_in;     ptz_ff <= ptz_in;
      cam0_ff <= cam0_in;   cam1_ff <= cam1_in;   cam2_ff <= cam2_in;
      xn_ff <= xn_in;       yn_ff <= yn_in;       r2_ff <= r2_in;     r4_ff <= r4_in;
      r6_ff <= r6_in;       r8_ff <= r8_in;       rad_ff <= rad_in;   cross_ff <= cross_in;
      tmp_ff <= tmp_in;     px_ff <= px_in;       py_ff <= py_in;
      dx_ff <= dx_in;       dy_ff <= dy_in;       dz_ff <= dz_in;
      pu_ff <= pu_in;       pv_ff <= pv_in;       limu_ff <= limu_in; limv_ff <= limv_in;
      norm_ff <= norm_in;   dist_ff <= dist_in;
      a_ff <= a_in;         b_ff <= b_in;         prod_ff <= prod_in; acc_ff <= acc_in;
      sh_ff <= sh_in;       rem_ff <= rem_in;     quo_ff <= quo_in;   den_ff <= den_in;
      neg_ff <= neg_in;     rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_busy_after_project: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.operation == cpd_pkg::OP_PROJECT)) |=> !req_ready)
      else $error("ready high right after a project beat");

   a_invalid_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.depth_invalid) |->
      (rsp_data.pixel_u == '0 && rsp_data.pixel_v == '0 &&
       rsp_data.distance == '0 && !rsp_data.in_view))
      else $error("zero-depth result carries nonzero fields");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER && uop.kind == cpd_pkg::UOP_DIV) |-> (den_ff != '0))
      else $error("divide started with zero depth");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && (!rsp_valid_ff || rsp_ready) && is_last) |=> req_ready)
      else $error("not idle after last camera result");
`endif

endmodule
